/* rtl/rbv_pkg.sv */
package rbv_pkg;

   localparam int COORD_WIDTH_DEF = 32;

   // result and fraction widths (Q2.30)
   localparam int Q_W = 32;
   localparam int FRAC_W = 30;

   // normalized magnitude, sum of three squares
   localparam int A_W = 30;
   localparam int SQ_W = 2 * A_W + 2;

   // square root and divide chains
   localparam int RAD_W = 64;
   localparam int ROOT_W = RAD_W / 2;
   localparam int DEN_W = ROOT_W + 1;
   localparam int NUM_W = RAD_W;
   localparam int QUO_W = 32;

   // magnitude width of the second pass (cross products or axis components)
   localparam int AXIS_W = 62;

   localparam int NORM_STAGES = 5;
   localparam int UNIT_LAT = NORM_STAGES + ROOT_W + QUO_W + 3;

   localparam logic signed [Q_W-1:0] ONE_Q30 = 32'sh4000_0000;
   localparam logic signed [33:0] OPP_LIMIT = 34'sd1072668082;
   localparam logic [63:0] AXIS_LIMIT = 64'd11529215046068470;

   localparam logic [1:0] CASE_NORMAL = 2'd0;
   localparam logic [1:0] CASE_ZERO = 2'd1;
   localparam logic [1:0] CASE_HALF = 2'd2;

   typedef struct packed {
      logic zero;
      logic [DEN_W-1:0] den;
      logic [2:0][Q_W-1:0] q;
   } unit_out_type;

endpackage

/* rtl/rbv_if.sv */
interface rbv_req_if #(
   parameter int COORD_WIDTH = rbv_pkg::COORD_WIDTH_DEF
);
   logic valid;
   logic ready;
   logic signed [COORD_WIDTH-1:0] from_x;
   logic signed [COORD_WIDTH-1:0] from_y;
   logic signed [COORD_WIDTH-1:0] from_z;
   logic signed [COORD_WIDTH-1:0] to_x;
   logic signed [COORD_WIDTH-1:0] to_y;
   logic signed [COORD_WIDTH-1:0] to_z;

   modport source (output valid, from_x, from_y, from_z, to_x, to_y, to_z, input ready);
   modport sink (input valid, from_x, from_y, from_z, to_x, to_y, to_z, output ready);
endinterface

interface rbv_rsp_if;
   logic valid;
   logic ready;
   logic signed [rbv_pkg::Q_W-1:0] quat_w;
   logic signed [rbv_pkg::Q_W-1:0] quat_x;
   logic signed [rbv_pkg::Q_W-1:0] quat_y;
   logic signed [rbv_pkg::Q_W-1:0] quat_z;
   logic [1:0] case_code;

   modport source (output valid, quat_w, quat_x, quat_y, quat_z, case_code, input ready);
   modport sink (input valid, quat_w, quat_x, quat_y, quat_z, case_code, output ready);
endinterface

/* rtl/rbv_unit.sv */
// Normalize three sign/magnitude components, take the square root of the
// sum of squares and divide each component by it, rounded to nearest.
// In direct mode the radicand and the numerators come in as given.
module rbv_unit #(
   parameter int MAG_W = rbv_pkg::COORD_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           enable,
   input  logic [2:0]                     in_neg,
   input  logic [2:0][MAG_W-1:0]          in_mag,
   input  logic                           in_direct,
   input  logic [rbv_pkg::RAD_W-1:0]      in_radicand,
   output rbv_pkg::unit_out_type          result
);

   localparam int A_W = rbv_pkg::A_W;
   localparam int RAD_W = rbv_pkg::RAD_W;
   localparam int ROOT_W = rbv_pkg::ROOT_W;
   localparam int DEN_W = rbv_pkg::DEN_W;
   localparam int NUM_W = rbv_pkg::NUM_W;
   localparam int QUO_W = rbv_pkg::QUO_W;
   localparam int Q_W = rbv_pkg::Q_W;
   localparam int POS_W = $clog2(MAG_W);
   localparam int EXT_W = (MAG_W > A_W) ? MAG_W : A_W;
   localparam int SH_W = $clog2(EXT_W);

   // ---- stage N1: largest magnitude
   logic [2:0]            n1_neg_ff;
   logic [2:0][MAG_W-1:0] n1_mag_ff;
   logic                  n1_direct_ff;
   logic [RAD_W-1:0]      n1_rad_ff;
   logic [MAG_W-1:0]      n1_max_ff;
   logic [MAG_W-1:0]      n1_max_in;
   logic [MAG_W-1:0]      max01;

   always_comb begin
      max01 = (in_mag[1] > in_mag[0]) ? in_mag[1] : in_mag[0];
      n1_max_in = (in_mag[2] > max01) ? in_mag[2] : max01;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         n1_neg_ff <= in_neg;
         n1_mag_ff <= in_mag;
         n1_direct_ff <= in_direct;
         n1_rad_ff <= in_radicand;
         n1_max_ff <= n1_max_in;
      end
   end

   // ---- stage N2: leading one, shift amounts
   logic [2:0]            n2_neg_ff;
   logic [2:0][MAG_W-1:0] n2_mag_ff;
   logic                  n2_direct_ff;
   logic [RAD_W-1:0]      n2_rad_ff;
   logic                  n2_zero_ff;
   logic [SH_W-1:0]       n2_rs_ff;
   logic [SH_W-1:0]       n2_ls_ff;
   logic [SH_W-1:0]       n2_rs_in;
   logic [SH_W-1:0]       n2_ls_in;
   logic [POS_W-1:0]      pos;

   always_comb begin
      pos = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (n1_max_ff[i]) pos = POS_W'(i);
      end
      if (int'(pos) >= A_W) begin
         n2_rs_in = SH_W'(int'(pos) - (A_W - 1));
         n2_ls_in = '0;
      end else begin
         n2_rs_in = '0;
         n2_ls_in = SH_W'((A_W - 1) - int'(pos));
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         n2_neg_ff <= n1_neg_ff;
         n2_mag_ff <= n1_mag_ff;
         n2_direct_ff <= n1_direct_ff;
         n2_rad_ff <= n1_rad_ff;
         n2_zero_ff <= (n1_max_ff == '0);
         n2_rs_ff <= n2_rs_in;
         n2_ls_ff <= n2_ls_in;
      end
   end

   // ---- stage N3: common shift into [2^29, 2^30)
   logic [2:0]            n3_neg_ff;
   logic [2:0][MAG_W-1:0] n3_mag_ff;
   logic                  n3_direct_ff;
   logic [RAD_W-1:0]      n3_rad_ff;
   logic                  n3_zero_ff;
   logic [2:0][A_W-1:0]   n3_a_ff;
   logic [2:0][A_W-1:0]   n3_a_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n3_a_in[i] = A_W'((EXT_W'(n2_mag_ff[i]) >> n2_rs_ff) << n2_ls_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         n3_neg_ff <= n2_neg_ff;
         n3_mag_ff <= n2_mag_ff;
         n3_direct_ff <= n2_direct_ff;
         n3_rad_ff <= n2_rad_ff;
         n3_zero_ff <= n2_zero_ff;
         n3_a_ff <= n3_a_in;
      end
   end

   // ---- stage N4: squares
   logic [2:0]            n4_neg_ff;
   logic [2:0][MAG_W-1:0] n4_mag_ff;
   logic                  n4_direct_ff;
   logic [RAD_W-1:0]      n4_rad_ff;
   logic                  n4_zero_ff;
   logic [2:0][A_W-1:0]   n4_a_ff;
   logic [2:0][2*A_W-1:0] n4_sq_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         n4_neg_ff <= n3_neg_ff;
         n4_mag_ff <= n3_mag_ff;
         n4_direct_ff <= n3_direct_ff;
         n4_rad_ff <= n3_rad_ff;
         n4_zero_ff <= n3_zero_ff;
         n4_a_ff <= n3_a_ff;
         for (int i = 0; i < 3; i++) begin
            n4_sq_ff[i] <= (2*A_W)'(n3_a_ff[i]) * (2*A_W)'(n3_a_ff[i]);
         end
      end
   end

   // ---- stage N5 (root stage 0): pick radicand and numerators
   logic [RAD_W-1:0]          sr_rem_ff  [ROOT_W+1];
   logic [ROOT_W-1:0]         sr_root_ff [ROOT_W+1];
   logic [2:0][NUM_W-1:0]     sr_base_ff [ROOT_W+1];
   logic [2:0]                sr_neg_ff  [ROOT_W+1];
   logic                      sr_rnd_ff  [ROOT_W+1];
   logic                      sr_zero_ff [ROOT_W+1];
   logic [rbv_pkg::SQ_W-1:0]  l2;

   assign l2 = rbv_pkg::SQ_W'(n4_sq_ff[0]) + rbv_pkg::SQ_W'(n4_sq_ff[1])
             + rbv_pkg::SQ_W'(n4_sq_ff[2]);

   always_ff @(posedge clock) begin
      if (enable) begin
         sr_rem_ff[0] <= n4_direct_ff ? n4_rad_ff : RAD_W'(l2);
         sr_root_ff[0] <= '0;
         for (int i = 0; i < 3; i++) begin
            sr_base_ff[0][i] <= n4_direct_ff ? NUM_W'(n4_mag_ff[i])
                              : NUM_W'({n4_a_ff[i], rbv_pkg::FRAC_W'(0)});
         end
         sr_neg_ff[0] <= n4_neg_ff;
         sr_rnd_ff[0] <= n4_direct_ff;
         sr_zero_ff[0] <= n4_zero_ff;
      end
   end

   // ---- square root, one result bit per stage
   for (genvar k = 0; k < ROOT_W; k++) begin : g_root
      localparam int B = ROOT_W - 1 - k;
      logic [RAD_W+1:0]  trial;
      logic              take;
      logic [RAD_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      assign trial = ((RAD_W+2)'(sr_root_ff[k]) << (B + 1)) + ((RAD_W+2)'(1) << (2 * B));
      assign take = (RAD_W+2)'(sr_rem_ff[k]) >= trial;
      assign rem_in = take ? RAD_W'((RAD_W+2)'(sr_rem_ff[k]) - trial) : sr_rem_ff[k];
      assign root_in = take ? (sr_root_ff[k] | (ROOT_W'(1) << B)) : sr_root_ff[k];

      always_ff @(posedge clock) begin
         if (enable) begin
            sr_rem_ff[k+1] <= rem_in;
            sr_root_ff[k+1] <= root_in;
            sr_base_ff[k+1] <= sr_base_ff[k];
            sr_neg_ff[k+1] <= sr_neg_ff[k];
            sr_rnd_ff[k+1] <= sr_rnd_ff[k];
            sr_zero_ff[k+1] <= sr_zero_ff[k];
         end
      end
   end

   // ---- round the root to nearest where asked
   logic [DEN_W-1:0]      rd_den_ff;
   logic [2:0][NUM_W-1:0] rd_base_ff;
   logic [2:0]            rd_neg_ff;
   logic                  rd_zero_ff;
   logic [DEN_W-1:0]      rd_den_in;
   logic                  bump;

   assign bump = sr_rnd_ff[ROOT_W] && (sr_rem_ff[ROOT_W] > RAD_W'(sr_root_ff[ROOT_W]));
   assign rd_den_in = DEN_W'(sr_root_ff[ROOT_W]) + DEN_W'(bump);

   always_ff @(posedge clock) begin
      if (enable) begin
         rd_den_ff <= rd_den_in;
         rd_base_ff <= sr_base_ff[ROOT_W];
         rd_neg_ff <= sr_neg_ff[ROOT_W];
         rd_zero_ff <= sr_zero_ff[ROOT_W];
      end
   end

   // ---- divide stage 0: add half the divisor, flag quotients past range
   logic [2:0][NUM_W-1:0] dv_rem_ff  [QUO_W+1];
   logic [2:0][QUO_W-1:0] dv_q_ff    [QUO_W+1];
   logic [2:0]            dv_over_ff [QUO_W+1];
   logic [DEN_W-1:0]      dv_den_ff  [QUO_W+1];
   logic [2:0]            dv_neg_ff  [QUO_W+1];
   logic                  dv_zero_ff [QUO_W+1];
   logic [2:0][NUM_W-1:0] num_in;
   logic [2:0]            over_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num_in[i] = rd_base_ff[i] + NUM_W'(rd_den_ff >> 1);
         over_in[i] = (num_in[i] >> QUO_W) >= NUM_W'(rd_den_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dv_rem_ff[0] <= num_in;
         dv_q_ff[0] <= '0;
         dv_over_ff[0] <= over_in;
         dv_den_ff[0] <= rd_den_ff;
         dv_neg_ff[0] <= rd_neg_ff;
         dv_zero_ff[0] <= rd_zero_ff;
      end
   end

   // ---- restoring divide, one quotient bit per stage in each lane
   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      localparam int B = QUO_W - 1 - k;
      logic [NUM_W+1:0]      shifted;
      logic [2:0][NUM_W-1:0] rem_in;
      logic [2:0][QUO_W-1:0] q_in;

      assign shifted = (NUM_W+2)'(dv_den_ff[k]) << B;

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            if ((NUM_W+2)'(dv_rem_ff[k][i]) >= shifted) begin
               rem_in[i] = NUM_W'((NUM_W+2)'(dv_rem_ff[k][i]) - shifted);
               q_in[i] = dv_q_ff[k][i] | (QUO_W'(1) << B);
            end else begin
               rem_in[i] = dv_rem_ff[k][i];
               q_in[i] = dv_q_ff[k][i];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            dv_rem_ff[k+1] <= rem_in;
            dv_q_ff[k+1] <= q_in;
            dv_over_ff[k+1] <= dv_over_ff[k];
            dv_den_ff[k+1] <= dv_den_ff[k];
            dv_neg_ff[k+1] <= dv_neg_ff[k];
            dv_zero_ff[k+1] <= dv_zero_ff[k];
         end
      end
   end

   // ---- saturate to one and reapply signs
   rbv_pkg::unit_out_type result_ff;
   rbv_pkg::unit_out_type result_in;
   logic [QUO_W-1:0]      qm;

   always_comb begin
      result_in.zero = dv_zero_ff[QUO_W];
      result_in.den = dv_den_ff[QUO_W];
      for (int i = 0; i < 3; i++) begin
         if (dv_over_ff[QUO_W][i] || dv_q_ff[QUO_W][i] > QUO_W'(rbv_pkg::ONE_Q30)) begin
            qm = QUO_W'(rbv_pkg::ONE_Q30);
         end else begin
            qm = dv_q_ff[QUO_W][i];
         end
         result_in.q[i] = dv_neg_ff[QUO_W][i] ? Q_W'(Q_W'(0) - Q_W'(qm)) : Q_W'(qm);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

/* rtl/rotation_between_vectors.sv */
// Shortest-arc rotation between two 3D vectors.
// req_ch carries a start and a target vector, signed Q16.16 of COORD_WIDTH
// bits each; rsp_ch returns the unit quaternion w, x, y, z (signed Q2.30)
// and a case code: normal, identity for a zero-length vector, or half turn
// for opposite vectors. Both channels move an item when valid and ready
// are high at a rising clock edge.
// One item is accepted every cycle while the output is not stalled. Each of
// the two normalize, square-root and divide passes takes UNIT_LAT stages,
// set by its 32-stage root chain and 32-stage divide chain, one bit per stage.
// The whole pipeline advances together; when the output register holds an
// item that is not taken, every stage holds and req_ch.ready drops, so no
// item is lost or repeated.
// Reset is synchronous and clears all valid bits; the first item can be
// offered in the cycle after reset falls.
module rotation_between_vectors #(
   parameter int COORD_WIDTH = rbv_pkg::COORD_WIDTH_DEF
) (
   input logic        clock,
   input logic        reset,
   rbv_req_if.sink    req_ch,
   rbv_rsp_if.source  rsp_ch
);

   localparam int W = COORD_WIDTH;
   localparam int Q_W = rbv_pkg::Q_W;
   localparam int LAT = rbv_pkg::UNIT_LAT;
   localparam int AXIS_W = rbv_pkg::AXIS_W;
   localparam int RAD_W = rbv_pkg::RAD_W;

   logic advance;
   logic rsp_valid_ff;

   assign advance = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance && !reset;

   // ---- stage P0: accept, split into sign and magnitude
   logic              p0_valid_ff;
   logic [2:0]        p0_fneg_ff;
   logic [2:0][W-1:0] p0_fmag_ff;
   logic [2:0]        p0_tneg_ff;
   logic [2:0][W-1:0] p0_tmag_ff;
   logic [2:0][W-1:0] fraw;
   logic [2:0][W-1:0] traw;

   assign fraw = {req_ch.from_z, req_ch.from_y, req_ch.from_x};
   assign traw = {req_ch.to_z, req_ch.to_y, req_ch.to_x};

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
      end else if (advance) begin
         p0_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            p0_fneg_ff[i] <= fraw[i][W-1];
            p0_fmag_ff[i] <= fraw[i][W-1] ? W'(~fraw[i] + W'(1)) : fraw[i];
            p0_tneg_ff[i] <= traw[i][W-1];
            p0_tmag_ff[i] <= traw[i][W-1] ? W'(~traw[i] + W'(1)) : traw[i];
         end
      end
   end

   // ---- first pass: unit vectors
   rbv_pkg::unit_out_type u1;
   rbv_pkg::unit_out_type u2;
   logic [LAT-1:0]        v1_ff;

   rbv_unit #(.MAG_W(W)) u_from (
      .clock(clock), .enable(advance), .in_neg(p0_fneg_ff), .in_mag(p0_fmag_ff),
      .in_direct(1'b0), .in_radicand('0), .result(u1)
   );

   rbv_unit #(.MAG_W(W)) u_to (
      .clock(clock), .enable(advance), .in_neg(p0_tneg_ff), .in_mag(p0_tmag_ff),
      .in_direct(1'b0), .in_radicand('0), .result(u2)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= '0;
      end else if (advance) begin
         v1_ff <= {v1_ff[LAT-2:0], p0_valid_ff};
      end
   end

   // ---- stage M1: products
   logic signed [Q_W-1:0] s [3];
   logic signed [Q_W-1:0] d [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s[i] = $signed(u1.q[i]);
         d[i] = $signed(u2.q[i]);
      end
   end

   logic                  m1_valid_ff;
   logic                  m1_zero_ff;
   logic signed [Q_W-1:0] m1_s_ff  [3];
   logic signed [63:0]    m1_dp_ff [3];
   logic signed [63:0]    m1_cp_ff [6];
   logic signed [63:0]    m1_xx_ff [2];

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else if (advance) begin
         m1_valid_ff <= v1_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m1_zero_ff <= u1.zero || u2.zero;
         for (int i = 0; i < 3; i++) begin
            m1_s_ff[i] <= s[i];
            m1_dp_ff[i] <= s[i] * d[i];
         end
         m1_cp_ff[0] <= s[1] * d[2];
         m1_cp_ff[1] <= s[2] * d[1];
         m1_cp_ff[2] <= s[2] * d[0];
         m1_cp_ff[3] <= s[0] * d[2];
         m1_cp_ff[4] <= s[0] * d[1];
         m1_cp_ff[5] <= s[1] * d[0];
         m1_xx_ff[0] <= s[0] * s[0];
         m1_xx_ff[1] <= s[1] * s[1];
      end
   end

   // ---- stage M2: dot, cross, squared xy length
   logic                  m2_valid_ff;
   logic                  m2_zero_ff;
   logic signed [Q_W-1:0] m2_s_ff  [3];
   logic signed [63:0]    m2_dot_ff;
   logic signed [63:0]    m2_cr_ff [3];
   logic [63:0]           m2_xy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff <= 1'b0;
      end else if (advance) begin
         m2_valid_ff <= m1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m2_zero_ff <= m1_zero_ff;
         m2_s_ff <= m1_s_ff;
         m2_dot_ff <= m1_dp_ff[0] + m1_dp_ff[1] + m1_dp_ff[2];
         m2_cr_ff[0] <= m1_cp_ff[0] - m1_cp_ff[1];
         m2_cr_ff[1] <= m1_cp_ff[2] - m1_cp_ff[3];
         m2_cr_ff[2] <= m1_cp_ff[4] - m1_cp_ff[5];
         m2_xy_ff <= $unsigned(m1_xx_ff[0] + m1_xx_ff[1]);
      end
   end

   // ---- stage M3: cosine to Q2.30, opposite and axis tests
   logic                  m3_valid_ff;
   logic                  m3_zero_ff;
   logic                  m3_opp_ff;
   logic                  m3_axsel_ff;
   logic signed [Q_W-1:0] m3_s_ff  [3];
   logic signed [33:0]    m3_c30_ff;
   logic signed [63:0]    m3_cr_ff [3];
   logic signed [63:0]    dot_rnd;
   logic signed [33:0]    m3_c30_in;

   assign dot_rnd = m2_dot_ff + 64'sd536870912;
   assign m3_c30_in = 34'(dot_rnd >>> rbv_pkg::FRAC_W);

   always_ff @(posedge clock) begin
      if (reset) begin
         m3_valid_ff <= 1'b0;
      end else if (advance) begin
         m3_valid_ff <= m2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m3_zero_ff <= m2_zero_ff;
         m3_opp_ff <= m3_c30_in < -rbv_pkg::OPP_LIMIT;
         m3_axsel_ff <= m2_xy_ff < rbv_pkg::AXIS_LIMIT;
         m3_s_ff <= m2_s_ff;
         m3_c30_ff <= m3_c30_in;
         m3_cr_ff <= m2_cr_ff;
      end
   end

   // ---- stage M4: second-pass operands
   logic                   m4_valid_ff;
   logic                   m4_zero_ff;
   logic                   m4_opp_ff;
   logic [2:0]             m4_neg_ff;
   logic [2:0][AXIS_W-1:0] m4_mag_ff;
   logic [RAD_W-1:0]       m4_rad_ff;
   logic signed [63:0]     p2v [3];
   logic signed [63:0]     onec;

   always_comb begin
      if (m3_opp_ff) begin
         if (m3_axsel_ff) begin
            p2v[0] = '0;
            p2v[1] = -64'(m3_s_ff[2]);
            p2v[2] = 64'(m3_s_ff[1]);
         end else begin
            p2v[0] = -64'(m3_s_ff[1]);
            p2v[1] = 64'(m3_s_ff[0]);
            p2v[2] = '0;
         end
      end else begin
         p2v = m3_cr_ff;
      end
      onec = 64'(m3_c30_ff) + 64'(rbv_pkg::ONE_Q30);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m4_valid_ff <= 1'b0;
      end else if (advance) begin
         m4_valid_ff <= m3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m4_zero_ff <= m3_zero_ff;
         m4_opp_ff <= m3_opp_ff;
         for (int i = 0; i < 3; i++) begin
            m4_neg_ff[i] <= p2v[i][63];
            m4_mag_ff[i] <= AXIS_W'(p2v[i][63] ? -p2v[i] : p2v[i]);
         end
         m4_rad_ff <= RAD_W'(onec) << (rbv_pkg::FRAC_W + 1);
      end
   end

   // ---- second pass: axis unit vector, or s and cross / s
   rbv_pkg::unit_out_type u3;
   logic [LAT-1:0]        s3v_ff;
   logic [LAT-1:0]        s3z_ff;
   logic [LAT-1:0]        s3o_ff;

   rbv_unit #(.MAG_W(AXIS_W)) u_second (
      .clock(clock), .enable(advance), .in_neg(m4_neg_ff), .in_mag(m4_mag_ff),
      .in_direct(!m4_opp_ff), .in_radicand(m4_rad_ff), .result(u3)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s3v_ff <= '0;
      end else if (advance) begin
         s3v_ff <= {s3v_ff[LAT-2:0], m4_valid_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3z_ff <= {s3z_ff[LAT-2:0], m4_zero_ff};
         s3o_ff <= {s3o_ff[LAT-2:0], m4_opp_ff};
      end
   end

   // ---- output register
   logic signed [Q_W-1:0] rsp_w_ff, rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic signed [Q_W-1:0] rsp_w_in, rsp_x_in, rsp_y_in, rsp_z_in;
   logic [1:0]            rsp_case_ff, rsp_case_in;
   logic [rbv_pkg::DEN_W:0] wm;

   always_comb begin
      wm = ((rbv_pkg::DEN_W+1)'(u3.den) + (rbv_pkg::DEN_W+1)'(1)) >> 1;
      rsp_x_in = $signed(u3.q[0]);
      rsp_y_in = $signed(u3.q[1]);
      rsp_z_in = $signed(u3.q[2]);
      if (s3z_ff[LAT-1]) begin
         rsp_w_in = rbv_pkg::ONE_Q30;
         rsp_x_in = '0;
         rsp_y_in = '0;
         rsp_z_in = '0;
         rsp_case_in = rbv_pkg::CASE_ZERO;
      end else if (s3o_ff[LAT-1]) begin
         rsp_w_in = '0;
         if (u3.zero) begin
            rsp_x_in = rbv_pkg::ONE_Q30;
            rsp_y_in = '0;
            rsp_z_in = '0;
         end
         rsp_case_in = rbv_pkg::CASE_HALF;
      end else begin
         if (wm > (rbv_pkg::DEN_W+1)'(rbv_pkg::ONE_Q30)) begin
            rsp_w_in = rbv_pkg::ONE_Q30;
         end else begin
            rsp_w_in = Q_W'(wm);
         end
         rsp_case_in = rbv_pkg::CASE_NORMAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s3v_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_w_ff <= rsp_w_in;
         rsp_x_ff <= rsp_x_in;
         rsp_y_ff <= rsp_y_in;
         rsp_z_ff <= rsp_z_in;
         rsp_case_ff <= rsp_case_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.quat_w = rsp_w_ff;
   assign rsp_ch.quat_x = rsp_x_ff;
   assign rsp_ch.quat_y = rsp_y_ff;
   assign rsp_ch.quat_z = rsp_z_ff;
   assign rsp_ch.case_code = rsp_case_ff;

   // ---- checks
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("result valid right after reset");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_w_ff <= rbv_pkg::ONE_Q30 && rsp_w_ff >= -rbv_pkg::ONE_Q30
                     && rsp_x_ff <= rbv_pkg::ONE_Q30 && rsp_x_ff >= -rbv_pkg::ONE_Q30
                     && rsp_y_ff <= rbv_pkg::ONE_Q30 && rsp_y_ff >= -rbv_pkg::ONE_Q30
                     && rsp_z_ff <= rbv_pkg::ONE_Q30 && rsp_z_ff >= -rbv_pkg::ONE_Q30))
      else $error("quaternion part out of range");

   a_normal_w: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_case_ff == rbv_pkg::CASE_NORMAL |-> rsp_w_ff > 0)
      else $error("normal rotation with non-positive w");

   a_half_axis: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_case_ff == rbv_pkg::CASE_HALF
      |-> rsp_w_ff == 0 && (rsp_x_ff != 0 || rsp_y_ff != 0 || rsp_z_ff != 0))
      else $error("half turn without an axis");

endmodule

/* dv/rbv_checker.sv */
`timescale 1ns / 1ps

module rbv_checker (
   input logic clock,
   input logic reset,
   rbv_req_if  req,
   rbv_rsp_if  rsp,
   output int  fail_count,
   output int  outstanding
);

   typedef struct {
      logic [rbv_pkg::Q_W-1:0] w;
      logic [rbv_pkg::Q_W-1:0] x;
      logic [rbv_pkg::Q_W-1:0] y;
      logic [rbv_pkg::Q_W-1:0] z;
      logic [1:0]              code;
   } quat_type;

   quat_type quat_queue[$];

   function automatic longint unsigned root_floor(input longint unsigned val);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > val) b = b >> 2;
      while (b != 0) begin
         if (val >= r + b) begin
            val = val - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // scale to unit length in Q2.30; returns 0 for an all-zero vector
   function automatic bit to_unit(input longint v[3], output longint u[3]);
      longint unsigned mag[3], a[3], m, sq, len, q;
      int rs, ls;
      sq = 0;
      rs = 0;
      ls = 0;
      for (int i = 0; i < 3; i++) mag[i] = (v[i] < 0) ? -v[i] : v[i];
      m = mag[0];
      if (mag[1] > m) m = mag[1];
      if (mag[2] > m) m = mag[2];
      if (m == 0) return 0;
      while (m >= (64'd1 << 30)) begin m = m >> 1; rs++; end
      while (m < (64'd1 << 29)) begin m = m << 1; ls++; end
      for (int i = 0; i < 3; i++) begin
         a[i] = (mag[i] >> rs) << ls;
         sq = sq + a[i] * a[i];
      end
      len = root_floor(sq);
      for (int i = 0; i < 3; i++) begin
         q = ((a[i] << 30) + (len >> 1)) / len;
         u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
      end
      return 1;
   endfunction

   function automatic longint round_div(input longint num, input longint unsigned den);
      longint unsigned m, q;
      m = (num < 0) ? -num : num;
      q = (m + (den >> 1)) / den;
      if (q > (64'd1 << 40)) q = 64'd1 << 40;
      return (num < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic [rbv_pkg::Q_W-1:0] sat_q30(input longint v);
      longint one;
      one = 64'sd1 << 30;
      if (v > one) v = one;
      if (v < -one) v = -one;
      return v[rbv_pkg::Q_W-1:0];
   endfunction

   function automatic quat_type shortest_arc(input longint f[3], input longint t[3]);
      quat_type res;
      longint s[3], d[3], ax[3], un[3], dot, c30, cx, cy, cz;
      longint unsigned xy, rad, r;
      longint one;
      bit ok_f, ok_t;
      one = 64'sd1 << 30;
      ok_f = to_unit(f, s);
      ok_t = to_unit(t, d);
      if (!ok_f || !ok_t) begin
         res = '{sat_q30(one), 0, 0, 0, rbv_pkg::CASE_ZERO};
         return res;
      end
      dot = s[0] * d[0] + s[1] * d[1] + s[2] * d[2];
      c30 = (dot + (64'sd1 << 29)) >>> 30;
      if (c30 < -longint'(rbv_pkg::OPP_LIMIT)) begin
         xy = s[0] * s[0] + s[1] * s[1];
         // fall back to the X axis when the start vector is close to Z
         if (xy < rbv_pkg::AXIS_LIMIT) begin
            ax[0] = 0; ax[1] = -s[2]; ax[2] = s[1];
         end else begin
            ax[0] = -s[1]; ax[1] = s[0]; ax[2] = 0;
         end
         if (!to_unit(ax, un)) begin
            un[0] = one; un[1] = 0; un[2] = 0;
         end
         res = '{0, sat_q30(un[0]), sat_q30(un[1]), sat_q30(un[2]), rbv_pkg::CASE_HALF};
         return res;
      end
      rad = longint'(2 * (one + c30)) << 30;
      r = root_floor(rad);
      if (r * r + r < rad) r++;
      cx = s[1] * d[2] - s[2] * d[1];
      cy = s[2] * d[0] - s[0] * d[2];
      cz = s[0] * d[1] - s[1] * d[0];
      res.w = sat_q30(longint'((r + 1) >> 1));
      res.code = rbv_pkg::CASE_NORMAL;
      if (r != 0) begin
         res.x = sat_q30(round_div(cx, r));
         res.y = sat_q30(round_div(cy, r));
         res.z = sat_q30(round_div(cz, r));
      end else begin
         res.x = 0; res.y = 0; res.z = 0;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      longint f[3], t[3];
      quat_type want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req.valid && req.ready) begin
            f[0] = req.from_x; f[1] = req.from_y; f[2] = req.from_z;
            t[0] = req.to_x; t[1] = req.to_y; t[2] = req.to_z;
            quat_queue.push_back(shortest_arc(f, t));
         end
         if (rsp.valid && rsp.ready) begin
            if (quat_queue.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("unexpected result item at %0t", $realtime);
            end else begin
               want = quat_queue.pop_front();
               if (want.w !== rsp.quat_w || want.x !== rsp.quat_x ||
                   want.y !== rsp.quat_y || want.z !== rsp.quat_z ||
                   want.code !== rsp.case_code) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display({"mismatch: expected w %h x %h y %h z %h code %0d,",
                               " got w %h x %h y %h z %h code %0d"},
                              want.w, want.x, want.y, want.z, want.code,
                              rsp.quat_w, rsp.quat_x, rsp.quat_y, rsp.quat_z,
                              rsp.case_code);
               end
            end
         end
      end
      outstanding = quat_queue.size();
   end

endmodule

/* dv/rotation_between_vectors_test.sv */
`timescale 1ns / 1ps

module rotation_between_vectors_test;

   localparam int RANDOM_ITEMS = 1000;
   localparam int CYCLE_LIMIT = 200000;
   localparam int TAIL_CYCLES = 200;
   localparam int LONG_HOLD = 500;

   logic clock = 0;
   logic reset = 1;
   int fail_count, outstanding, cycles;
   int tx_idle, rx_idle, hold_left;
   logic req_fire = 0;
   logic hold_req = 0, hold_seen = 0;

   rbv_req_if #(.COORD_WIDTH(32)) req_ch ();
   rbv_rsp_if rsp_ch ();

   rotation_between_vectors #(.COORD_WIDTH(32)) u_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch)
   );

   rbv_checker u_checker (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .fail_count(fail_count), .outstanding(outstanding)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      req_fire <= req_ch.valid && req_ch.ready;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // receiver: random stalls plus a long hold-off on request
   initial begin
      rsp_ch.ready = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle);
         end
      end
   end

   task automatic offer(input logic signed [31:0] fx, fy, fz, tx, ty, tz);
      while ($urandom_range(99) < tx_idle) begin
         req_ch.valid <= 0;
         @(negedge clock);
      end
      req_ch.valid <= 1;
      req_ch.from_x <= fx; req_ch.from_y <= fy; req_ch.from_z <= fz;
      req_ch.to_x <= tx; req_ch.to_y <= ty; req_ch.to_z <= tz;
      do @(negedge clock); while (!req_fire);
   endtask

   task automatic drain();
      req_ch.valid <= 0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   function automatic logic signed [31:0] rand_coord();
      logic signed [31:0] v;
      v = $urandom;
      return v >>> $urandom_range(31);
   endfunction

   initial begin
      logic signed [31:0] fx, fy, fz, tx, ty, tz;
      int k, sel;
      tx_idle = 15;
      rx_idle = 54;
      req_ch.valid = 0;
      {req_ch.from_x, req_ch.from_y, req_ch.from_z} = '0;
      {req_ch.to_x, req_ch.to_y, req_ch.to_z} = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      offer(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
            32'sh80000000, 32'sh80000000, 32'sh80000000);
      offer(32'sh80000000, 0, 0, 32'sh7fffffff, 0, 0);
      offer(0, 0, 0, 32'sh10000, 0, 0);
      offer(32'sh10000, 2, 3, 0, 0, 0);
      offer(0, 0, 0, 0, 0, 0);
      offer(32'sh10000, 0, 0, 32'sh10000, 0, 0);
      offer(1, 0, 0, 0, 1, 0);
      offer(0, 0, 32'sh10000, 0, 0, -32'sh10000);
      offer(0, 32'sh30000, 0, 0, -32'sh30000, 0);
      offer(32'sh10000, 32'sh10000, 0, -32'sh20000, -32'sh20000, 0);
      offer(32'sh10000, 0, 0, -32'sh10000, 32'sh40, 0);
      offer(32'sh100, 32'sh8, 32'sh10000, -32'sh100, -32'sh8, -32'sh10000);
      offer(-1, -1, -1, 1, 1, 1);
      offer(32'sh7fffffff, -1, 1, 32'sh7fffffff, 1, -1);
      offer(32'sh12345, -32'sh6789a, 32'sh2468, -32'sh13579, 32'sh2222, 32'sh77777);
      offer(32'sh80000000, 32'sh80000000, 0, 0, 32'sh7fffffff, 32'sh80000000);
      offer(0, 0, 1, 1, 0, 0);
      drain();

      // long receiver hold-off while the sender keeps offering
      hold_req <= ~hold_req;
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         if (k == RANDOM_ITEMS / 3) begin
            tx_idle = 54;
            rx_idle = 15;
         end else if (k == 2 * RANDOM_ITEMS / 3) begin
            tx_idle = 0;
            rx_idle = 0;
         end
         fx = rand_coord(); fy = rand_coord(); fz = rand_coord();
         sel = $urandom_range(99);
         if (sel < 55) begin
            tx = rand_coord(); ty = rand_coord(); tz = rand_coord();
         end else if (sel < 80) begin
            // near-opposite target, sometimes with the start near the Z axis
            if (sel < 68) begin
               fx = fx >>> $urandom_range(20, 31);
               fy = fy >>> $urandom_range(20, 31);
            end
            tx = -(fx >>> 1) + $signed($urandom_range(15)) - 7;
            ty = -(fy >>> 1) + $signed($urandom_range(15)) - 7;
            tz = -(fz >>> 1) + $signed($urandom_range(15)) - 7;
         end else if (sel < 90) begin
            tx = fx + $signed($urandom_range(255)) - 128;
            ty = fy; tz = fz;
         end else begin
            tx = rand_coord(); ty = rand_coord(); tz = rand_coord();
            if (sel < 95) {fx, fy, fz} = '0;
            else {tx, ty, tz} = '0;
         end
         offer(fx, fy, fz, tx, ty, tz);
      end
      req_ch.valid <= 0;
      do @(negedge clock); while (outstanding != 0);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
